// ===== hw/rtl/rfd_pkg.sv =====
package rfd_pkg;

    localparam int MAX_NODES  = 32;
    localparam int NODE_BITS  = $clog2(MAX_NODES);
    localparam int RING_BITS  = $clog2(MAX_NODES + 1);
    localparam int ADDR_BITS  = 2 * NODE_BITS;
    localparam int MEM_DEPTH  = MAX_NODES * MAX_NODES;
    localparam int COUNT_BITS = 16;
    localparam int CFG_BITS   = 6;
    localparam logic [CFG_BITS-1:0] NODES_RESET = CFG_BITS'(8);
    localparam logic [COUNT_BITS-1:0] COUNT_TOP = '1;

    typedef enum logic [1:0] {
        CMD_TEST   = 2'd0,
        CMD_FAIL   = 2'd1,
        CMD_REPAIR = 2'd2,
        CMD_NONE   = 2'd3
    } cmd_code_t;

    typedef enum logic [2:0] {
        KIND_TEST  = 3'd0,
        KIND_SKIP  = 3'd1,
        KIND_FAULT = 3'd2,
        KIND_REPAIR = 3'd3,
        KIND_ERROR = 3'd4
    } kind_t;

    typedef enum logic [1:0] {
        CLASS_IGNORE = 2'd0,
        CLASS_SIMPLE = 2'd1,
        CLASS_TEST   = 2'd2
    } item_class_t;

    // controller -> datapath
    typedef struct packed {
        logic clear;      // clearing pass step
        logic load;       // input transfer taken
        logic rd_entries; // read self and tested entries
        logic upd_self;   // write self entry, work out tested entry
        logic wr_tested;  // write tested entry, arm merge
        logic merge;      // merge sweep running
        logic out_test;   // load test result
        logic advance;    // step to next successor
    } rfd_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic        clear_done;
        item_class_t in_class;
        logic        tested_faulty;
        logic        merge_done;
        logic        walk_done;
    } rfd_status_t;

endpackage

// ===== hw/rtl/rfd_ctrl.sv =====
module rfd_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic                out_ready,
    output logic                out_valid,
    input  rfd_pkg::rfd_status_t stat,
    output rfd_pkg::rfd_cmd_t   cmd
);

    typedef enum logic [6:0] {
        ST_CLEAR = 7'b0000001,
        ST_IDLE  = 7'b0000010,
        ST_READ  = 7'b0000100,
        ST_SELF  = 7'b0001000,
        ST_WRE   = 7'b0010000,
        ST_MERGE = 7'b0100000,
        ST_OUT   = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = (state_reg == ST_OUT);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear = 1'b1;
                if (stat.clear_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    if (stat.in_class == rfd_pkg::CLASS_SIMPLE)
                    begin
                        state_next = ST_OUT;
                    end
                    else if (stat.in_class == rfd_pkg::CLASS_TEST)
                    begin
                        state_next = ST_READ;
                    end
                end
            end
            ST_READ:
            begin
                cmd.rd_entries = 1'b1;
                state_next     = ST_SELF;
            end
            ST_SELF:
            begin
                cmd.upd_self = 1'b1;
                state_next   = ST_WRE;
            end
            ST_WRE:
            begin
                cmd.wr_tested = 1'b1;
                if (stat.tested_faulty)
                begin
                    cmd.out_test = 1'b1;
                    state_next   = ST_OUT;
                end
                else
                begin
                    state_next = ST_MERGE;
                end
            end
            ST_MERGE:
            begin
                cmd.merge = 1'b1;
                if (stat.merge_done)
                begin
                    cmd.out_test = 1'b1;
                    state_next   = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (out_ready)
                begin
                    if (stat.walk_done)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        cmd.advance = 1'b1;
                        state_next  = ST_READ;
                    end
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

endmodule

// ===== hw/rtl/rfd_datapath.sv =====
module rfd_datapath (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_valid,
    input  logic [rfd_pkg::CFG_BITS-1:0]   cfg_data,
    input  logic [1:0]                     in_command,
    input  logic [rfd_pkg::NODE_BITS-1:0]  in_node,
    input  rfd_pkg::rfd_cmd_t              cmd,
    output rfd_pkg::rfd_status_t           stat,
    output logic [31:0]                    out_data,
    output logic                           out_last
);

    localparam int NB = rfd_pkg::NODE_BITS;
    localparam int RB = rfd_pkg::RING_BITS;
    localparam int AB = rfd_pkg::ADDR_BITS;
    localparam int CB = rfd_pkg::COUNT_BITS;

    // entry: known bit over count
    logic [CB:0] mem [rfd_pkg::MEM_DEPTH];
    logic [CB:0] rda_reg, rdb_reg;
    logic [AB-1:0] rda_addr, rdb_addr, wr_addr;
    logic [CB:0]   wr_data;
    logic          wr_en;

    logic [rfd_pkg::CFG_BITS-1:0] nodes_reg;
    logic [rfd_pkg::MAX_NODES-1:0] flags_reg;
    logic [AB-1:0] clr_reg;
    logic [NB-1:0] a_reg, t_reg;
    logic [CB:0]   e_reg;
    logic          ovf_reg, st_reg;
    logic [RB-1:0] mi_reg;
    logic          mpend_reg;
    logic [NB-1:0] mpi_reg;
    logic [31:0]   out_reg;
    logic          last_reg;

    logic [RB-1:0] ring_n;
    logic [RB-1:0] node_ext, t_inc;
    logic          in_range;
    logic [CB:0]   self_after, e_old, e_new;
    logic          e_ovf, st_now;
    logic          merge_wr;
    rfd_pkg::item_class_t in_class;
    rfd_pkg::kind_t       load_kind;

    always_comb
    begin
        if (nodes_reg < rfd_pkg::CFG_BITS'(2))
            ring_n = RB'(2);
        else if (nodes_reg > rfd_pkg::CFG_BITS'(rfd_pkg::MAX_NODES))
            ring_n = RB'(rfd_pkg::MAX_NODES);
        else
            ring_n = RB'(nodes_reg);
    end

    assign node_ext = RB'(in_node);
    assign in_range = node_ext < ring_n;

    always_comb
    begin
        in_class = rfd_pkg::CLASS_IGNORE;
        if (in_range)
        begin
            case (in_command)
                rfd_pkg::CMD_TEST:
                begin
                    if (flags_reg[in_node])
                        in_class = rfd_pkg::CLASS_SIMPLE;
                    else
                        in_class = rfd_pkg::CLASS_TEST;
                end
                rfd_pkg::CMD_FAIL, rfd_pkg::CMD_REPAIR:
                    in_class = rfd_pkg::CLASS_SIMPLE;
                default:
                    in_class = rfd_pkg::CLASS_IGNORE;
            endcase
        end
    end

    assign stat.in_class = in_class;

    // result kind for a single-result item
    always_comb
    begin
        case (in_command)
            rfd_pkg::CMD_FAIL:
            begin
                if (flags_reg[in_node])
                    load_kind = rfd_pkg::KIND_ERROR;
                else
                    load_kind = rfd_pkg::KIND_FAULT;
            end
            rfd_pkg::CMD_REPAIR:
                load_kind = rfd_pkg::KIND_REPAIR;
            default:
                load_kind = rfd_pkg::KIND_SKIP;
        endcase
    end

    // successor of t around the ring
    always_comb
    begin
        t_inc = RB'(t_reg) + RB'(1);
        if (t_inc == ring_n)
            t_inc = '0;
    end

    // self and tested entry update
    always_comb
    begin
        st_now     = flags_reg[t_reg];
        self_after = rda_reg[CB] ? rda_reg : {1'b1, CB'(0)};
        e_old      = (t_reg == a_reg) ? self_after : rdb_reg;
        e_new      = e_old;
        e_ovf      = 1'b0;
        if (!e_old[CB])
            e_new = {1'b1, CB'(st_now)};
        else if (e_old[0] != st_now)
        begin
            if (e_old[CB-1:0] == rfd_pkg::COUNT_TOP)
                e_ovf = 1'b1;
            else
                e_new = {1'b1, e_old[CB-1:0] + CB'(1)};
        end
    end

    // merge: rda = tested row entry, rdb = tester row entry
    assign merge_wr = mpend_reg && (mpi_reg != t_reg) && rda_reg[CB] &&
                      (!rdb_reg[CB] || (rda_reg[CB-1:0] > rdb_reg[CB-1:0]));

    always_comb
    begin
        rda_addr = {t_reg, mi_reg[NB-1:0]};
        rdb_addr = {a_reg, mi_reg[NB-1:0]};
        if (cmd.rd_entries)
        begin
            rda_addr = {a_reg, a_reg};
            rdb_addr = {a_reg, t_reg};
        end
    end

    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = {a_reg, mpi_reg};
        wr_data = rda_reg;
        if (cmd.clear)
        begin
            wr_en   = 1'b1;
            wr_addr = clr_reg;
            wr_data = '0;
        end
        else if (cmd.upd_self)
        begin
            wr_en   = 1'b1;
            wr_addr = {a_reg, a_reg};
            wr_data = self_after;
        end
        else if (cmd.wr_tested)
        begin
            wr_en   = 1'b1;
            wr_addr = {a_reg, t_reg};
            wr_data = e_reg;
        end
        else if (merge_wr)
        begin
            wr_en = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rda_reg <= mem[rda_addr];
        rdb_reg <= mem[rdb_addr];
    end

    assign stat.clear_done    = cmd.clear && (clr_reg == AB'(rfd_pkg::MEM_DEPTH - 1));
    assign stat.tested_faulty = st_reg;
    assign stat.merge_done    = (mi_reg == ring_n) && !mpend_reg;
    assign stat.walk_done     = last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nodes_reg <= rfd_pkg::NODES_RESET;
            flags_reg <= '0;
            clr_reg   <= '0;
            mpend_reg <= 1'b0;
            mi_reg    <= '0;
        end
        else
        begin
            if (cfg_valid)
                nodes_reg <= cfg_data;
            if (cmd.clear)
                clr_reg <= clr_reg + AB'(1);
            if (cmd.load && in_range)
            begin
                if (in_command == rfd_pkg::CMD_FAIL)
                    flags_reg[in_node] <= 1'b1;
                else if (in_command == rfd_pkg::CMD_REPAIR)
                    flags_reg[in_node] <= 1'b0;
            end
            if (cmd.wr_tested)
                mi_reg <= '0;
            else if (cmd.merge && (mi_reg != ring_n))
                mi_reg <= mi_reg + RB'(1);
            mpend_reg <= cmd.merge && (mi_reg != ring_n);
        end
    end

    always_ff @(posedge clk)
    begin
        mpi_reg <= mi_reg[NB-1:0];
        if (cmd.load)
        begin
            a_reg    <= in_node;
            t_reg    <= (RB'(in_node) + RB'(1) == ring_n) ? '0 : in_node + NB'(1);
            last_reg <= 1'b1;
            out_reg  <= {19'd0, in_node, in_node, load_kind};
        end
        if (cmd.advance)
            t_reg <= t_inc[NB-1:0];
        if (cmd.upd_self)
        begin
            e_reg   <= e_new;
            ovf_reg <= e_ovf;
            st_reg  <= st_now;
        end
        if (cmd.out_test)
        begin
            out_reg  <= {ovf_reg, e_reg[CB-1:0], e_reg[CB], st_reg, t_reg, a_reg,
                         rfd_pkg::KIND_TEST};
            last_reg <= !st_reg || (t_reg == a_reg);
        end
    end

    assign out_data = out_reg;
    assign out_last = last_reg;

endmodule

// ===== hw/rtl/ring_fault_diagnosis_engine.sv =====
// Channel   Direction  Payload
// s_axis    in         tdata[1:0] command, [6:2] node, [7] zero
// m_axis    out        tuser kind, tdata tester..overflow, tlast = last of the item's results
// cfg       in         cfg_data[5:0] nodes_in_use
//
// After reset a clearing pass sweeps the 1024-entry diagnosis memory, one entry
// per cycle; s_tready stays low meanwhile, cfg writes still taken.
// Fault, repair and faulty-tester items load their result directly, then the result waits.
// Test items: per tested node read, self update and tested write, plus, for a
// fault-free node, a row merge through the single write port, then its result transfer.
// A stalled m_tready holds the walk; one item is in flight at a time.
module ring_fault_diagnosis_engine (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // command[1:0], node[6:2]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // tester[4:0], tested[9:5],
                                   // tested_faulty[10], entry_known[11],
                                   // entry_count[27:12], overflow[28]
    output logic [2:0]  m_tuser,   // kind[2:0]
    output logic        m_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [5:0]  cfg_data   // nodes_in_use
);

    rfd_pkg::rfd_cmd_t    cmd;
    rfd_pkg::rfd_status_t stat;
    logic [31:0]          dp_data;

    // configuration register always writable
    assign cfg_ready = 1'b1;

    // datapath word: kind in the low bits, the rest above
    assign m_tuser = dp_data[2:0];
    assign m_tdata = {3'b000, dp_data[31:3]};

    rfd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .out_ready (m_tready),
        .out_valid (m_tvalid),
        .stat      (stat),
        .cmd       (cmd)
    );

    rfd_datapath u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_data   (cfg_data),
        .in_command (s_tdata[1:0]),
        .in_node    (s_tdata[6:2]),
        .cmd        (cmd),
        .stat       (stat),
        .out_data   (dp_data),
        .out_last   (m_tlast)
    );

endmodule

// ===== test/tb_ring_fault_diagnosis_engine.sv =====
module tb_ring_fault_diagnosis_engine;

    localparam int LIMIT_CYCLES = 10000000;
    localparam int HOLD_CYCLES  = 400;
    localparam int NB           = rfd_pkg::NODE_BITS;
    localparam int CB           = rfd_pkg::COUNT_BITS;
    localparam int MN           = rfd_pkg::MAX_NODES;
    localparam int MD           = rfd_pkg::MEM_DEPTH;

    // one result transfer as it is expected on m_axis
    typedef struct {
        rfd_pkg::kind_t kind;
        logic [NB-1:0]  tester;
        logic [NB-1:0]  tested;
        logic           faulty;
        logic           known;
        logic [CB-1:0]  count;
        logic           ovf;
        logic           last;
    } diag_result_t;

    // Scoreboard: own copy of flags and diagnosis rows, queue of results still owed
    class diag_scoreboard;
        bit                           flag[MN];
        bit                           known[MD];
        logic [CB-1:0]                cnt[MD];
        logic [rfd_pkg::CFG_BITS-1:0] ring_reg;
        diag_result_t                 owed[$];
        int                           errors;
        int                           items;
        int                           results;
        int                           tests_made;

        function new();
            ring_reg = rfd_pkg::NODES_RESET;
            foreach (flag[i]) flag[i] = 1'b0;
            foreach (known[i])
            begin
                known[i] = 1'b0;
                cnt[i]   = '0;
            end
        endfunction

        function int ring_n();
            int n;
            n = ring_reg;
            if (n < 2) n = 2;
            if (n > MN) n = MN;
            return n;
        endfunction

        function void add(rfd_pkg::kind_t k, int a, int b, bit f, bit kn,
                          logic [CB-1:0] c, bit o, bit l);
            diag_result_t r;
            r.kind = k; r.tester = NB'(a); r.tested = NB'(b); r.faulty = f;
            r.known = kn; r.count = c; r.ovf = o; r.last = l;
            owed.push_back(r);
        endfunction

        // tester a probes node b; row merge when b is fault-free
        function bit probe(int a, int b, int n, output bit ovf);
            bit st;
            int self_e;
            int e;
            int s;
            int d;
            st = flag[b];
            self_e = a * MN + a;
            e = a * MN + b;
            ovf = 1'b0;
            if (!known[self_e])
            begin
                known[self_e] = 1'b1;
                cnt[self_e]   = '0;
            end
            if (!known[e])
            begin
                known[e] = 1'b1;
                cnt[e]   = CB'(st);
            end
            else if (cnt[e][0] != st)
            begin
                if (cnt[e] == rfd_pkg::COUNT_TOP)
                    ovf = 1'b1;
                else
                    cnt[e] = cnt[e] + CB'(1);
            end
            if (!st)
            begin
                for (int i = 0; i < n; i++)
                begin
                    s = b * MN + i;
                    d = a * MN + i;
                    if (i != b && known[s] && (!known[d] || cnt[s] > cnt[d]))
                    begin
                        known[d] = 1'b1;
                        cnt[d]   = cnt[s];
                    end
                end
            end
            return st;
        endfunction

        // accepted input transfer
        function void note_input(rfd_pkg::cmd_code_t cmd, int node);
            int  n;
            int  t;
            bit  st;
            bit  ovf;
            bit  done;
            n = ring_n();
            if (node >= n) return;
            case (cmd)
                rfd_pkg::CMD_FAIL:
                begin
                    items++;
                    if (flag[node])
                        add(rfd_pkg::KIND_ERROR, node, node, 0, 0, '0, 0, 1);
                    else
                    begin
                        flag[node] = 1'b1;
                        add(rfd_pkg::KIND_FAULT, node, node, 0, 0, '0, 0, 1);
                    end
                end
                rfd_pkg::CMD_REPAIR:
                begin
                    items++;
                    flag[node] = 1'b0;
                    add(rfd_pkg::KIND_REPAIR, node, node, 0, 0, '0, 0, 1);
                end
                rfd_pkg::CMD_TEST:
                begin
                    items++;
                    if (flag[node])
                        add(rfd_pkg::KIND_SKIP, node, node, 0, 0, '0, 0, 1);
                    else
                    begin
                        for (int k = 0; k < MN; k++)
                        begin
                            t = (node + k + 1) % n;
                            st = probe(node, t, n, ovf);
                            done = !st || (t == node);
                            add(rfd_pkg::KIND_TEST, node, t, st, known[node*MN+t],
                                cnt[node*MN+t], ovf, done);
                            tests_made++;
                            if (done) break;
                        end
                    end
                end
                default: ;
            endcase
        endfunction

        // accepted result transfer
        function void check_result(logic [31:0] d, logic [2:0] u, logic l);
            diag_result_t e;
            results++;
            if (owed.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result tdata=%h tuser=%0d tlast=%b",
                         $time, d, u, l);
                return;
            end
            e = owed.pop_front();
            if (u !== e.kind || d[4:0] !== e.tester || d[9:5] !== e.tested ||
                d[10] !== e.faulty || d[11] !== e.known || d[27:12] !== e.count ||
                d[28] !== e.ovf || l !== e.last)
            begin
                errors++;
                $display("%0t: expected kind=%0d tester=%0d tested=%0d faulty=%b",
                         $time, e.kind, e.tester, e.tested, e.faulty);
                $display("%0t:   expected known=%b count=%0d ovf=%b last=%b",
                         $time, e.known, e.count, e.ovf, e.last);
                $display("%0t:   actual kind=%0d tester=%0d tested=%0d faulty=%b",
                         $time, u, d[4:0], d[9:5], d[10]);
                $display("%0t:   actual known=%b count=%0d ovf=%b last=%b",
                         $time, d[11], d[27:12], d[28], l);
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        m_tlast;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [5:0]  cfg_data;

    diag_scoreboard sb;
    int  cycles;
    bit  hold_rx;
    bit  rx_enable;

    ring_fault_diagnosis_engine dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // monitors: sample handshakes at the edge, before this edge's updates land
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                sb.ring_reg = cfg_data;
            if (s_tvalid && s_tready)
                sb.note_input(rfd_pkg::cmd_code_t'(s_tdata[1:0]), s_tdata[6:2]);
            if (m_tvalid && m_tready)
                sb.check_result(m_tdata, m_tuser, m_tlast);
        end
    end

    // receiver: random ready with mostly short stalls, an occasional long one,
    // and a long hold-off on request while the sender keeps offering
    initial
    begin
        int run;
        m_tready = 1'b0;
        wait (rx_enable);
        forever
        begin
            if (hold_rx)
            begin
                @(posedge clk) m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_rx = 1'b0;
            end
            run = $urandom_range(1, 20);
            repeat (run) @(posedge clk) m_tready <= 1'b1;
            if ($urandom_range(0, 99) < 6)
                run = $urandom_range(20, 60);
            else
                run = $urandom_range(0, 3);
            repeat (run) @(posedge clk) m_tready <= 1'b0;
        end
    end

    // called just after a rising edge; returns at the edge that takes the transfer
    task automatic send_item(rfd_pkg::cmd_code_t cmd, logic [4:0] node);
        int gap;
        gap = $urandom_range(0, 99);
        if (gap < 50)
            gap = 0;
        else if (gap < 95)
            gap = $urandom_range(1, 3);
        else
            gap = $urandom_range(20, 50);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, node, cmd};
        do @(posedge clk); while (!s_tready);
    endtask

    // lower valid and wait for every owed result, then a little slack
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.owed.size() != 0) @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic write_ring(logic [5:0] v);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // random traffic: mostly in-ring events with real work, some noise
    task automatic random_phase(int quota, bit with_hold);
        int                 n;
        int                 done_cnt;
        int                 r;
        rfd_pkg::cmd_code_t cmd;
        logic [4:0]         node;
        n = sb.ring_n();
        done_cnt = 0;
        while (done_cnt < quota)
        begin
            if (with_hold && done_cnt == 5)
                hold_rx = 1'b1;
            r = $urandom_range(0, 99);
            if (r < 45)
                cmd = rfd_pkg::CMD_TEST;
            else if (r < 70)
                cmd = rfd_pkg::CMD_FAIL;
            else if (r < 95)
                cmd = rfd_pkg::CMD_REPAIR;
            else
                cmd = rfd_pkg::CMD_NONE;
            if ($urandom_range(0, 99) < 8)
                node = 5'($urandom_range(0, 31));
            else
                node = 5'($urandom_range(0, n - 1));
            if (cmd != rfd_pkg::CMD_NONE && node < n)
                done_cnt++;
            send_item(cmd, node);
        end
    endtask

    initial
    begin
        int ring_set[7];
        sb        = new();
        cycles    = 0;
        hold_rx   = 1'b0;
        rx_enable = 1'b0;
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        cfg_valid = 1'b0;
        cfg_data  = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        rx_enable = 1'b1;

        // directed, ring of 8 from reset
        send_item(rfd_pkg::CMD_TEST, 5'd0);    // first test: unknown entries, merge
        send_item(rfd_pkg::CMD_FAIL, 5'd1);
        send_item(rfd_pkg::CMD_FAIL, 5'd1);    // fault on a faulty node
        send_item(rfd_pkg::CMD_TEST, 5'd0);    // walks past a faulty successor
        send_item(rfd_pkg::CMD_TEST, 5'd1);    // faulty tester is skipped
        send_item(rfd_pkg::CMD_REPAIR, 5'd1);
        send_item(rfd_pkg::CMD_REPAIR, 5'd1);  // repair of a fault-free node
        send_item(rfd_pkg::CMD_TEST, 5'd0);    // status change recorded by increment
        send_item(rfd_pkg::CMD_TEST, 5'd8);    // outside the ring
        send_item(rfd_pkg::CMD_FAIL, 5'd31);   // outside the ring
        send_item(rfd_pkg::CMD_NONE, 5'd2);    // unused command
        for (int i = 1; i < 8; i++)
            send_item(rfd_pkg::CMD_FAIL, 5'(i));
        send_item(rfd_pkg::CMD_TEST, 5'd0);    // every successor faulty: self test
        send_item(rfd_pkg::CMD_TEST, 5'd7);
        send_item(rfd_pkg::CMD_REPAIR, 5'd4);
        send_item(rfd_pkg::CMD_TEST, 5'd0);
        send_item(rfd_pkg::CMD_TEST, 5'd6);
        drain();

        // register settings: extremes and values out of range included
        ring_set = '{2, 32, 0, 63, 5, 17, 12};
        foreach (ring_set[p])
        begin
            write_ring(6'(ring_set[p]));
            random_phase(55, p == 1);
            drain();
        end

        repeat (100) @(posedge clk);
        $display("%0d events accepted, %0d results checked, %0d nodes tested",
                 sb.items, sb.results, sb.tests_made);
        $display("ring sizes 8, 2, 32, 0, 63, 5, 17, 12 with a long receiver hold-off");
        if (sb.errors == 0 && sb.owed.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/rfd_pkg.sv
hw/rtl/rfd_ctrl.sv
hw/rtl/rfd_datapath.sv
hw/rtl/ring_fault_diagnosis_engine.sv
test/tb_ring_fault_diagnosis_engine.sv
